// ===== rtl/battery_monitor_gauge_macros.svh =====
// Assertion macros shared by the battery monitor RTL.
// Each macro expects a clock named clk and a reset named rst in the enclosing scope.
`ifndef BATTERY_MONITOR_GAUGE_MACROS_SVH
`define BATTERY_MONITOR_GAUGE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BMG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("battery monitor assertion failed");

// Next-cycle implication, checked out of reset.
`define BMG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("battery monitor assertion failed");

`endif

// ===== rtl/bmg_pkg.sv =====
// Package for the battery monitor gauge: field widths, alarm and register codes,
// reciprocal constants and the control struct for the coulomb counter. No dependencies.
package bmg_pkg;

  localparam int CodeW = 12;
  localparam int TickW = 16;
  localparam int DataW = 32;
  localparam int DivisorW = 20;
  localparam int HourSumW = 28;
  localparam int CountW = 12;
  localparam int MulW = 29;
  localparam int ProdW = 2 * MulW;
  localparam int CfgIdxW = 3;

  localparam logic [CountW-1:0] TICKS_PER_HOUR = CountW'(3600);
  localparam longint UvPerMv = 1000;

  // Exact floor division by constants through a scaled reciprocal.
  localparam int MvShift = 38;
  localparam logic [MulW-1:0] MV_RECIP =
    MulW'(((64'd1 << MvShift) + UvPerMv - 1) / UvPerMv);
  localparam int HourShift = 39;
  localparam logic [MulW-1:0] HOUR_RECIP =
    MulW'(((64'd1 << HourShift) + 64'(TICKS_PER_HOUR) - 1) / 64'(TICKS_PER_HOUR));
  localparam int QuotW = 16;

  localparam logic [1:0] ALARM_NORMAL = 2'd0;
  localparam logic [1:0] ALARM_OVER_V = 2'd1;
  localparam logic [1:0] ALARM_OVER_I = 2'd2;
  localparam logic [1:0] ALARM_HYST = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_MAX_V = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HYST_V = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_I = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_HYST_I = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_UV_CODE = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DIV_TOP = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_DIV_BOT = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_CAP_LIM = 3'd7;

  typedef struct packed {
    logic add;
    logic commit;
  } coul_ctl_t;

endpackage

// ===== rtl/bmg_divider.sv =====
// Restoring radix-2 divider: 32-bit dividend by 20-bit divisor, one quotient bit per cycle.
// Depends on bmg_pkg. A zero divisor yields an all-ones quotient.
module bmg_divider
  import bmg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DataW-1:0]    dividend,
  input  logic [DivisorW-1:0] divisor,
  output logic                busy,
  output logic [DataW-1:0]    quotient
);

  logic [DataW-1:0]    quo;
  logic [DivisorW-1:0] rem;
  logic [DivisorW-1:0] dvs;
  logic [4:0]          count;
  logic [DivisorW:0]   shifted;
  logic [DivisorW+1:0] diff;
  logic                fits;

  assign shifted = {rem, quo[DataW-1]};
  assign diff = {1'b0, shifted} - {2'b00, dvs};
  assign fits = !diff[DivisorW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 5'd1;
      if (count == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DataW-2:0], fits};
      rem <= fits ? diff[DivisorW-1:0] : shifted[DivisorW-1:0];
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/bmg_coulomb.sv =====
// Coulomb counter state: partial hour sum, tick count, hour total and used capacity.
// Depends on bmg_pkg; the hour quotient arrives from the shared multiplier.
module bmg_coulomb
  import bmg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  coul_ctl_t           ctl,
  input  logic                second_tick,
  input  logic [TickW-1:0]    tick_current,
  input  logic [DataW-1:0]    capacity_limit,
  input  logic [QuotW-1:0]    quot_mag,
  output logic [HourSumW-1:0] hour_sum,
  output logic [DataW:0]      capacity
);

  logic [CountW-1:0] second_count;
  logic [DataW-1:0]  hour_total;
  logic [DataW:0]    quot_s;
  logic [DataW-1:0]  hour_total_next;
  logic              below_limit;

  assign below_limit = $signed(capacity) < $signed({capacity_limit[DataW-1], capacity_limit});
  assign quot_s = hour_sum[HourSumW-1] ? -{17'b0, quot_mag} : {17'b0, quot_mag};
  assign hour_total_next = hour_total + quot_s[DataW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_sum <= '0;
      second_count <= '0;
      hour_total <= '0;
      capacity <= '0;
    end else if (ctl.add) begin
      if (second_tick && below_limit) begin
        hour_sum <= hour_sum + {{(HourSumW-TickW){tick_current[TickW-1]}}, tick_current};
        second_count <= second_count + CountW'(1);
      end
    end else if (ctl.commit) begin
      if (second_count == TICKS_PER_HOUR) begin
        hour_total <= hour_total_next;
        hour_sum <= '0;
        second_count <= '0;
        capacity <= {hour_total_next[DataW-1], hour_total_next};
      end else begin
        capacity <= {hour_total[DataW-1], hour_total} + quot_s;
      end
    end
  end

endmodule

// ===== rtl/battery_monitor_gauge.sv =====
// Battery monitor with running voltage and current averages, alarm classification and
// a coulomb counter. Depends on bmg_pkg, bmg_divider, bmg_coulomb and the macros header.
//
// Usage: an item (voltage_code, current_code, second_tick, tick_current) is taken on
// in_valid && in_ready. One result item (alarm_state, voltage_average, current_average,
// capacity_used) follows on out_valid/out_ready for every input item.
// Configuration registers are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while no item is in flight, as the block does not enforce it.
// The voltage scaling uses one shared multiplier three times, then a radix-2 divider by
// the lower divider resistor runs; the coulomb counter uses the multiplier while the
// divider runs. One item is processed at a time: no new item is taken until the result
// of the last one is registered.
// The result sits in an output register; the next item is accepted while it waits,
// and that item stalls in its last step until the earlier result is taken.
// Reset (rst, synchronous) clears averages, alarm history, counters and loads the
// default register values; no clearing pass is needed.
`include "battery_monitor_gauge_macros.svh"

module battery_monitor_gauge
  import bmg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CodeW-1:0]    voltage_code,
  input  logic [CodeW-1:0]    current_code,
  input  logic                second_tick,
  input  logic [TickW-1:0]    tick_current,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          alarm_state,
  output logic [DataW-1:0]    voltage_average,
  output logic [DataW-1:0]    current_average,
  output logic [DataW-1:0]    capacity_used,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [DataW-1:0]    cfg_data
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL1 = 4'd1;
  localparam logic [3:0] ST_MUL2 = 4'd2;
  localparam logic [3:0] ST_MUL3 = 4'd3;
  localparam logic [3:0] ST_DSTART = 4'd4;
  localparam logic [3:0] ST_CAP = 4'd5;
  localparam logic [3:0] ST_WAIT = 4'd6;
  localparam logic [3:0] ST_AVG = 4'd7;
  localparam logic [3:0] ST_CLS = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  logic [DataW-1:0]    max_voltage_mv;
  logic [15:0]         voltage_hysteresis_mv;
  logic [CodeW-1:0]    max_current;
  logic [CodeW-1:0]    current_hysteresis;
  logic [15:0]         microvolts_per_code;
  logic [DivisorW-1:0] divider_top_ohms;
  logic [DivisorW-1:0] divider_bottom_ohms;
  logic [DataW-1:0]    capacity_limit;

  logic [CodeW-1:0] vcode;
  logic [CodeW-1:0] icode;
  logic             tick;
  logic [TickW-1:0] tcur;

  logic [DataW-1:0] avg_voltage;
  logic [DataW-1:0] avg_current;
  logic [1:0]       last_alarm;

  logic [MulW-1:0]  mul_a;
  logic [MulW-1:0]  mul_b;
  logic [ProdW-1:0] prod;

  logic [DivisorW:0]    res_sum;
  logic [HourSumW-1:0]  hour_sum;
  logic [HourSumW-1:0]  hour_sum_abs;
  logic [DataW:0]       capacity;
  logic                 div_busy;
  logic [DataW-1:0]     vin;
  coul_ctl_t            coul_ctl;

  logic [DataW-1:0] vsum;
  logic [DataW:0]   isum;
  logic [DataW:0]   isum_adj;
  logic [DataW:0]   vlimit;
  logic [DataW:0]   ilimit;
  logic [DataW:0]   imax;
  logic [DataW:0]   iavg_ext;
  logic             over_v;
  logic             over_i;
  logic             hyst;
  logic [1:0]       alarm;

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_voltage_mv <= DataW'(14400);
      voltage_hysteresis_mv <= 16'd200;
      max_current <= 12'd4095;
      current_hysteresis <= 12'd50;
      microvolts_per_code <= 16'd806;
      divider_top_ohms <= 20'd100000;
      divider_bottom_ohms <= 20'd10000;
      capacity_limit <= 32'h7FFF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_V: max_voltage_mv <= cfg_data;
        REG_HYST_V: voltage_hysteresis_mv <= cfg_data[15:0];
        REG_MAX_I: max_current <= cfg_data[CodeW-1:0];
        REG_HYST_I: current_hysteresis <= cfg_data[CodeW-1:0];
        REG_UV_CODE: microvolts_per_code <= cfg_data[15:0];
        REG_DIV_TOP: divider_top_ohms <= cfg_data[DivisorW-1:0];
        REG_DIV_BOT: divider_bottom_ohms <= cfg_data[DivisorW-1:0];
        REG_CAP_LIM: capacity_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      vcode <= voltage_code;
      icode <= current_code;
      tick <= second_tick;
      tcur <= tick_current;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MUL3;
      ST_MUL3: state_next = ST_DSTART;
      ST_DSTART: state_next = ST_CAP;
      ST_CAP: state_next = ST_WAIT;
      ST_WAIT: if (!div_busy) state_next = ST_AVG;
      ST_AVG: state_next = ST_CLS;
      ST_CLS: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign res_sum = {1'b0, divider_top_ohms} + {1'b0, divider_bottom_ohms};
  assign hour_sum_abs = hour_sum[HourSumW-1] ? -hour_sum : hour_sum;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MUL1: begin
        mul_a = MulW'(vcode);
        mul_b = MulW'(microvolts_per_code);
      end
      ST_MUL2: begin
        mul_a = MulW'(prod[27:0]);
        mul_b = MV_RECIP;
      end
      ST_MUL3: begin
        mul_a = MulW'(res_sum);
        mul_b = MulW'(prod[MvShift+18:MvShift]);
      end
      ST_DSTART: begin
        mul_a = MulW'(hour_sum_abs[HourSumW-2:0]);
        mul_b = HOUR_RECIP;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign coul_ctl.add = (state == ST_MUL1);
  assign coul_ctl.commit = (state == ST_CAP);

  bmg_divider u_div (
    .clk(clk),
    .rst(rst),
    .start(state == ST_DSTART),
    .dividend(prod[DataW-1:0]),
    .divisor(divider_bottom_ohms),
    .busy(div_busy),
    .quotient(vin)
  );

  bmg_coulomb u_coul (
    .clk(clk),
    .rst(rst),
    .ctl(coul_ctl),
    .second_tick(tick),
    .tick_current(tcur),
    .capacity_limit(capacity_limit),
    .quot_mag(prod[HourShift+QuotW-1:HourShift]),
    .hour_sum(hour_sum),
    .capacity(capacity)
  );

  assign vsum = avg_voltage + vin;
  assign isum = {avg_current[DataW-1], avg_current} + {21'b0, icode};
  assign isum_adj = isum + {32'b0, isum[DataW]};

  assign vlimit = {1'b0, max_voltage_mv} + {17'b0, voltage_hysteresis_mv};
  assign ilimit = {20'b0, {1'b0, max_current} + {1'b0, current_hysteresis}};
  assign imax = {21'b0, max_current};
  assign iavg_ext = {avg_current[DataW-1], avg_current};
  assign over_v = {1'b0, avg_voltage} > vlimit;
  assign over_i = $signed(iavg_ext) >= $signed(ilimit);
  assign hyst = ((last_alarm == ALARM_OVER_V) && (avg_voltage > max_voltage_mv)) ||
                ((last_alarm == ALARM_OVER_I) && ($signed(iavg_ext) > $signed(imax)));

  always_comb begin
    if (over_v) begin
      alarm = ALARM_OVER_V;
    end else if (over_i) begin
      alarm = ALARM_OVER_I;
    end else if (hyst) begin
      alarm = ALARM_HYST;
    end else begin
      alarm = ALARM_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_voltage <= '0;
      avg_current <= '0;
      last_alarm <= ALARM_NORMAL;
    end else if (state == ST_AVG) begin
      avg_voltage <= (avg_voltage == '0) ? vin : {1'b0, vsum[DataW-1:1]};
      avg_current <= (avg_current == '0) ? DataW'(icode) : isum_adj[DataW:1];
    end else if ((state == ST_CLS) && state_next == ST_IDLE && (over_v || over_i)) begin
      last_alarm <= alarm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_CLS) && (state_next == ST_IDLE)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_CLS) && (state_next == ST_IDLE)) begin
      alarm_state <= alarm;
      voltage_average <= avg_voltage;
      current_average <= avg_current;
      capacity_used <= capacity[DataW-1:0];
    end
  end

  `BMG_ASSERT_SAME(a_divider_idle_when_ready, in_ready, !div_busy)
  `BMG_ASSERT_SAME(a_result_from_last_step, $rose(out_valid), $past(state) == ST_CLS)
  `BMG_ASSERT_NEXT(a_alarm_history_kept, last_alarm != ALARM_NORMAL,
                   last_alarm != ALARM_NORMAL)

endmodule

// ===== tb/sv/battery_monitor_gauge_tb.sv =====
// Self-checking testbench for battery_monitor_gauge: a scoreboard class predicts every
// result item from the accepted input items; plain tasks drive the input handshake and an
// initial block drives out_ready. Depends on bmg_pkg and the battery_monitor_gauge RTL.
`timescale 1ns / 1ps

import bmg_pkg::*;

typedef struct packed {
  logic [1:0]       alarm;
  logic [DataW-1:0] v_avg;
  logic [DataW-1:0] i_avg;
  logic [DataW-1:0] cap;
} reading_t;

class fuel_gauge_board;
  localparam int HOUR_TICKS = 3600;
  localparam logic [31:0] UV_PER_MV = 32'd1000;

  logic [31:0] max_v;
  logic [15:0] hyst_v;
  logic [11:0] max_i;
  logic [11:0] hyst_i;
  logic [15:0] uv_per_code;
  logic [19:0] div_top;
  logic [19:0] div_bot;
  logic signed [31:0] cap_limit;

  logic [31:0] v_avg;
  logic signed [31:0] i_avg;
  logic [1:0] last_alarm;
  logic signed [27:0] hour_sum;
  logic [11:0] sec_count;
  logic signed [31:0] hour_total;

  reading_t pending[$];
  int errors;

  function new();
    max_v = 32'd14400;
    hyst_v = 16'd200;
    max_i = 12'd4095;
    hyst_i = 12'd50;
    uv_per_code = 16'd806;
    div_top = 20'd100000;
    div_bot = 20'd10000;
    cap_limit = 32'sh7FFF_FFFF;
    v_avg = '0;
    i_avg = '0;
    last_alarm = ALARM_NORMAL;
    hour_sum = '0;
    sec_count = '0;
    hour_total = '0;
    errors = 0;
  endfunction

  function void write_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] data);
    case (idx)
      REG_MAX_V: max_v = data;
      REG_HYST_V: hyst_v = data[15:0];
      REG_MAX_I: max_i = data[11:0];
      REG_HYST_I: hyst_i = data[11:0];
      REG_UV_CODE: uv_per_code = data[15:0];
      REG_DIV_TOP: div_top = data[19:0];
      REG_DIV_BOT: div_bot = data[19:0];
      REG_CAP_LIM: cap_limit = data;
      default: ;
    endcase
  endfunction

  function longint used_capacity();
    longint hs;
    hs = hour_sum;
    return longint'(hour_total) + hs / longint'(HOUR_TICKS);
  endfunction

  function void take_sample(logic [CodeW-1:0] vcode, logic [CodeW-1:0] icode,
                            logic tick, logic [TickW-1:0] tcur);
    logic [31:0] mv;
    logic [31:0] span;
    logic [31:0] vin;
    longint acc;
    logic [1:0] alarm;
    reading_t r;
    mv = (32'(vcode) * 32'(uv_per_code)) / UV_PER_MV;
    span = 32'(div_top) + 32'(div_bot);
    vin = span * mv;
    vin = (div_bot != 0) ? vin / 32'(div_bot) : '1;
    if (v_avg == 0) begin
      v_avg = vin;
    end else begin
      v_avg = (v_avg + vin) >> 1;
    end
    if (i_avg == 0) begin
      i_avg = $signed(32'(icode));
    end else begin
      acc = longint'(i_avg) + longint'(icode);
      i_avg = 32'(acc / 2);
    end

    alarm = ALARM_NORMAL;
    if ({32'b0, v_avg} > 64'(max_v) + 64'(hyst_v)) begin
      alarm = ALARM_OVER_V;
      last_alarm = alarm;
    end else if (longint'(i_avg) >= longint'(max_i) + longint'(hyst_i)) begin
      alarm = ALARM_OVER_I;
      last_alarm = alarm;
    end else if ((last_alarm == ALARM_OVER_V && v_avg > max_v) ||
                 (last_alarm == ALARM_OVER_I && longint'(i_avg) > longint'(max_i))) begin
      alarm = ALARM_HYST;
    end

    if (tick && used_capacity() < longint'(cap_limit)) begin
      hour_sum = hour_sum + $signed(tcur);
      sec_count = sec_count + 12'd1;
      if (sec_count == HOUR_TICKS) begin
        hour_total = 32'(used_capacity());
        hour_sum = '0;
        sec_count = '0;
      end
    end

    r.alarm = alarm;
    r.v_avg = v_avg;
    r.i_avg = i_avg;
    r.cap = 32'(used_capacity());
    pending.push_back(r);
  endfunction

  function void match_reading(logic [1:0] alarm, logic [DataW-1:0] v,
                              logic [DataW-1:0] i, logic [DataW-1:0] c);
    reading_t want;
    if (pending.size() == 0) begin
      $error("result item arrived with no input item outstanding");
      errors++;
      return;
    end
    want = pending.pop_front();
    if (alarm !== want.alarm) begin
      $error("alarm_state: expected %0d, got %0d", want.alarm, alarm);
      errors++;
    end
    if (v !== want.v_avg) begin
      $error("voltage_average: expected %0d, got %0d", want.v_avg, v);
      errors++;
    end
    if (i !== want.i_avg) begin
      $error("current_average: expected %0d, got %0d", $signed(want.i_avg), $signed(i));
      errors++;
    end
    if (c !== want.cap) begin
      $error("capacity_used: expected %0d, got %0d", $signed(want.cap), $signed(c));
      errors++;
    end
  endfunction
endclass

module battery_monitor_gauge_tb;
  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [CodeW-1:0] voltage_code;
  logic [CodeW-1:0] current_code;
  logic second_tick;
  logic [TickW-1:0] tick_current;
  logic out_valid;
  logic out_ready;
  logic [1:0] alarm_state;
  logic [DataW-1:0] voltage_average;
  logic [DataW-1:0] current_average;
  logic [DataW-1:0] capacity_used;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [DataW-1:0] cfg_data;

  fuel_gauge_board board = new();
  bit quiet;

  battery_monitor_gauge dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .voltage_code(voltage_code),
    .current_code(current_code),
    .second_tick(second_tick),
    .tick_current(tick_current),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .alarm_state(alarm_state),
    .voltage_average(voltage_average),
    .current_average(current_average),
    .capacity_used(capacity_used),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  initial begin
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.match_reading(alarm_state, voltage_average, current_average, capacity_used);
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send(logic [CodeW-1:0] v, logic [CodeW-1:0] i, logic t,
                      logic [TickW-1:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    voltage_code <= v;
    current_code <= i;
    second_tick <= t;
    tick_current <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_sample(v, i, t, c);
    @(negedge clk);
  endtask

  task automatic send_random(bit all_ticks, bit mostly_positive);
    logic [CodeW-1:0] v;
    logic [CodeW-1:0] i;
    logic t;
    logic [TickW-1:0] c;
    int r;
    r = $urandom_range(0, 9);
    v = (r == 0) ? '0 : (r == 1) ? '1 : CodeW'($urandom);
    r = $urandom_range(0, 9);
    i = (r == 0) ? '0 : (r == 1) ? '1 : CodeW'($urandom);
    t = all_ticks ? 1'b1 : 1'($urandom);
    c = TickW'($urandom);
    if (mostly_positive && $urandom_range(0, 4) != 0) c[TickW-1] = 1'b0;
    send(v, i, t, c);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic put_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic load_regs(logic [31:0] mv, logic [31:0] hv, logic [31:0] mi,
                           logic [31:0] hi, logic [31:0] uv, logic [31:0] top,
                           logic [31:0] bot, logic [31:0] cap);
    put_reg(REG_MAX_V, mv);
    put_reg(REG_HYST_V, hv);
    put_reg(REG_MAX_I, mi);
    put_reg(REG_HYST_I, hi);
    put_reg(REG_UV_CODE, uv);
    put_reg(REG_DIV_TOP, top);
    put_reg(REG_DIV_BOT, bot);
    put_reg(REG_CAP_LIM, cap);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_of(logic [31:0] lo, logic [31:0] hi,
                                          logic [31:0] typ);
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return typ;
  endfunction

  task automatic load_random_regs();
    logic [31:0] bot_typ;
    logic [31:0] cap_typ;
    bot_typ = $urandom_range(1000, 100000);
    cap_typ = 32'(board.used_capacity() + longint'($urandom_range(0, 250)) - 50);
    load_regs(pick_of(32'd0, 32'hFFFF_FFFF, $urandom_range(5000, 40000)),
              pick_of(32'd0, 32'd65535, $urandom_range(0, 5000)),
              pick_of(32'd0, 32'd4095, $urandom_range(0, 4095)),
              pick_of(32'd0, 32'd4095, $urandom_range(0, 1000)),
              pick_of(32'd0, 32'd65535, $urandom_range(500, 1000)),
              pick_of(32'd0, 32'd1000000, $urandom_range(0, 10 * bot_typ)),
              pick_of(32'd0, 32'd1000000, bot_typ),
              pick_of(32'h8000_0000, 32'h7FFF_FFFF, cap_typ));
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    voltage_code = '0;
    current_code = '0;
    second_tick = 1'b0;
    tick_current = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Settings after reset, with the extremes of every input field.
    send(12'd0, 12'd0, 1'b0, 16'h0000);
    send(12'd4095, 12'd4095, 1'b1, 16'h7FFF);
    send(12'd4095, 12'd0, 1'b1, 16'h8000);
    send(12'd0, 12'd4095, 1'b0, 16'h0000);
    send(12'd2000, 12'd100, 1'b1, 16'h0000);
    wait_idle();

    // The scaled voltage and its average wrap; a zero limit stops the counter.
    load_regs(32'hFFFF_FFFF, 32'd65535, 32'd0, 32'd0, 32'd65535, 32'd1000000, 32'd1,
              32'd0);
    send(12'd4095, 12'd4095, 1'b1, 16'h8000);
    send(12'd4095, 12'd1, 1'b1, 16'h7FFF);
    send(12'd1234, 12'd0, 1'b0, 16'h0000);
    wait_idle();

    // A zero lower resistor saturates the scaled voltage.
    load_regs(32'd0, 32'd0, 32'd4095, 32'd4095, 32'd806, 32'd100000, 32'd0,
              32'h8000_0000);
    send(12'd100, 12'd2000, 1'b1, 16'h1234);
    send(12'd4095, 12'd4095, 1'b1, 16'hFFFF);
    wait_idle();

    // Over-current, then the current falls back through the hysteresis zone.
    load_regs(32'hFFFF_0000, 32'd65535, 32'd2000, 32'd1000, 32'd806, 32'd100000,
              32'd10000, 32'h7FFF_FFFF);
    repeat (2) send(12'd2820, 12'd4095, 1'b1, 16'd100);
    repeat (3) send(12'd2820, 12'd2200, 1'b1, 16'd100);
    repeat (2) send(12'd2820, 12'd0, 1'b0, 16'd0);
    wait_idle();

    // A run of ticks with mostly positive currents builds up the partial hour sum.
    load_regs(32'd14400, 32'd200, 32'd4095, 32'd50, 32'd806, 32'd100000, 32'd10000,
              32'h7FFF_FFFF);
    repeat (40) send_random(1'b1, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      quiet = (ph == 2);
      load_random_regs();
      repeat (90) send_random(1'b0, ph[0]);
      wait_idle();
    end
    quiet = 1'b0;

    repeat (60) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
